// ===== design/hbpr_pkg.sv =====
`timescale 1ns / 1ps

package hbpr_pkg;

    // Block configuration.
    localparam int SAMPLES_PER_AVERAGE = 20;
    localparam int TICK_RATE           = 1000000;

    // Field and state widths.
    localparam int ADC_W  = 12;
    localparam int PER_W  = 14;
    localparam int SUM_W  = $clog2(SAMPLES_PER_AVERAGE * 4095 + 1);
    localparam int CNT_W  = $clog2(SAMPLES_PER_AVERAGE + 1);

    // Shared divider: the dividend width must be even, two quotient bits per cycle.
    localparam int DIV_W     = 30;
    localparam int DVSR_W    = 16;
    localparam int REM_W     = DVSR_W + 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Limits and reset values.
    localparam int PERIOD_MAX   = 16383;
    localparam int MIN_FREQ     = 100;
    localparam int RESET_FREQ   = 1000;
    localparam int RESET_PERIOD = 1000;
    localparam int ADC_MAX      = 4095;
    localparam int BYTE_MAX     = 255;
    localparam int WIDE_MAX     = 65535;
    localparam int LAST_REG     = 5;
    localparam int MAX_WR_LEN   = 7;

    // Register numbers and query codes.
    localparam logic [7:0] REG_DIR      = 8'h00;
    localparam logic [7:0] REG_SPD8     = 8'h01;
    localparam logic [7:0] REG_SPD16_LO = 8'h02;
    localparam logic [7:0] REG_SPD16_HI = 8'h03;
    localparam logic [7:0] REG_FREQ_LO  = 8'h04;
    localparam logic [7:0] REG_FREQ_HI  = 8'h05;
    localparam logic [7:0] Q_AVG_BYTE   = 8'h10;
    localparam logic [7:0] Q_AVG_LO     = 8'h20;
    localparam logic [7:0] Q_AVG_HI     = 8'h21;
    localparam logic [7:0] Q_VERSION    = 8'hFE;
    localparam logic [7:0] Q_ADDRESS    = 8'hFF;

    localparam logic [7:0] ADDR_BASE    = 8'h20;
    localparam logic [7:0] VERSION_CODE = 8'h01;

    // Motor direction codes.
    localparam logic [7:0] DIR_HALT = 8'd0;
    localparam logic [7:0] DIR_FWD  = 8'd1;
    localparam logic [7:0] DIR_REV  = 8'd2;

    // Reply lengths.
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_ONE  = 2'd1;
    localparam logic [1:0] LEN_TWO  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_PERIOD,
        S_MUL_DUTY,
        S_DIV_DUTY,
        S_DIV_AVG,
        S_MUL_BYTE,
        S_DIV_BYTE,
        S_DONE
    } t_state;

endpackage

// ===== design/hbpr_if.sv =====
`timescale 1ns / 1ps

// Input channel: one bus transaction or one converter sample per item.
interface hbpr_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  reg_addr;
    logic [3:0]  byte_count;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic [11:0] adc_sample;

    modport source (
        output valid, action, reg_addr, byte_count, data_byte0, data_byte1,
               data_byte2, data_byte3, data_byte4, data_byte5, adc_sample,
        input  ready
    );
    modport sink (
        input  valid, action, reg_addr, byte_count, data_byte0, data_byte1,
               data_byte2, data_byte3, data_byte4, data_byte5, adc_sample,
        output ready
    );
endinterface

// Output channel: one result item per input item.
interface hbpr_out_if;
    logic        valid;
    logic        ready;
    logic        read_valid;
    logic [1:0]  read_len;
    logic [15:0] read_data;
    logic [13:0] reload_value;
    logic [13:0] compare_forward;
    logic [13:0] compare_reverse;
    logic [11:0] adc_average;
    logic [7:0]  adc_average_byte;

    modport source (
        output valid, read_valid, read_len, read_data, reload_value,
               compare_forward, compare_reverse, adc_average, adc_average_byte,
        input  ready
    );
    modport sink (
        input  valid, read_valid, read_len, read_data, reload_value,
               compare_forward, compare_reverse, adc_average, adc_average_byte,
        output ready
    );
endinterface

// ===== design/hbridge_pwm_register_block_core.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Carries
// i_in      | in        | valid / ready      | bus transaction or converter sample
// o_out     | out       | valid / ready      | read reply and current PWM / ADC state
// i_cfg_*   | in        | write enable only  | address_select strap offset
//
// Forward or reverse writes and the sample that closes an averaging block pass through
// the accept state, two radix-4 divider passes, one multiply state and one result state.
// Writes with stop or an unknown direction skip the second pass; every other item goes
// from the accept state straight to the result state.
// Reset is synchronous and needs no clearing pass. A finished result waits in the
// output register while the next item is accepted; a second finished one stalls input.
module hbridge_pwm_register_block_core
    import hbpr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,
    hbpr_in_if.sink      i_in,
    hbpr_out_if.source   o_out
);

    // Architectural state.
    t_state               r_state, n_state;
    logic [3:0]           r_addr_sel;
    logic [7:0]           r_dir, n_dir;
    logic [7:0]           r_spd8, n_spd8;
    logic [15:0]          r_spd16, n_spd16;
    logic                 r_wide, n_wide;
    logic [15:0]          r_freq, n_freq;
    logic [PER_W-1:0]     r_period, n_period;
    logic [PER_W-1:0]     r_cmp_a, n_cmp_a;
    logic [PER_W-1:0]     r_cmp_b, n_cmp_b;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [CNT_W-1:0]     r_smp_cnt, n_smp_cnt;
    logic [ADC_W-1:0]     r_avg, n_avg;
    logic [7:0]           r_avg_byte, n_avg_byte;

    // Shared divider.
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DVSR_W-1:0]    r_dvsr, n_dvsr;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [REM_W-1:0]     step_rem;
    logic [DIV_W-1:0]     step_quo;
    logic                 div_last;

    // Shared multiplier.
    logic [DVSR_W-1:0]    mul_a;
    logic [PER_W-1:0]     mul_b;
    logic [DIV_W-1:0]     mul_p;

    // Read reply of the current item.
    logic                 r_rd_valid, n_rd_valid;
    logic [1:0]           r_rd_len, n_rd_len;
    logic [15:0]          r_rd_data, n_rd_data;

    // Output register.
    logic                 r_o_valid, n_o_valid;
    logic                 r_o_rd_valid;
    logic [1:0]           r_o_rd_len;
    logic [15:0]          r_o_rd_data;
    logic [PER_W-1:0]     r_o_period;
    logic [PER_W-1:0]     r_o_cmp_a;
    logic [PER_W-1:0]     r_o_cmp_b;
    logic [ADC_W-1:0]     r_o_avg;
    logic [7:0]           r_o_avg_byte;
    logic                 out_free;
    logic                 out_load;

    // Item decode.
    logic                 in_fire;
    logic                 dec_write;
    logic                 dec_query;
    logic                 dec_avg;
    logic [SUM_W-1:0]     sum_add;
    logic [7:0]           data_arr [6];
    logic [7:0]           wr_byte [6];
    logic [5:0]           wr_mark;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_o_valid || o_out.ready;
    assign out_load   = (r_state == S_DONE) && out_free;

    assign data_arr[0] = i_in.data_byte0;
    assign data_arr[1] = i_in.data_byte1;
    assign data_arr[2] = i_in.data_byte2;
    assign data_arr[3] = i_in.data_byte3;
    assign data_arr[4] = i_in.data_byte4;
    assign data_arr[5] = i_in.data_byte5;

    // Decode the item: which registers a write touches, and whether a sample closes a block.
    always_comb begin
        logic [2:0] reg_lo;
        logic [2:0] off;
        reg_lo  = i_in.reg_addr[2:0];
        off     = '0;
        wr_mark = '0;
        for (int t = 0; t < 6; t++) begin
            wr_byte[t] = '0;
            if (i_in.reg_addr <= 8'(LAST_REG) && 3'(t) >= reg_lo) begin
                off        = 3'(t) - reg_lo;
                wr_byte[t] = data_arr[off];
                wr_mark[t] = ({1'b0, off} + 4'd1) < i_in.byte_count;
            end
        end
        dec_write = !i_in.action && (i_in.byte_count > 4'd1)
                    && (i_in.byte_count <= 4'(MAX_WR_LEN))
                    && (i_in.reg_addr <= 8'(LAST_REG));
        dec_query = !i_in.action && (i_in.byte_count == 4'd1);
        dec_avg   = i_in.action && (r_smp_cnt == CNT_W'(SAMPLES_PER_AVERAGE - 1));
        sum_add   = r_sum + SUM_W'(i_in.adc_sample);
    end

    // Two restoring division steps per cycle.
    always_comb begin
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            rem = {rem[REM_W-2:0], quo[DIV_W-1]};
            quo = {quo[DIV_W-2:0], 1'b0};
            if (rem >= REM_W'(r_dvsr)) begin
                rem    = rem - REM_W'(r_dvsr);
                quo[0] = 1'b1;
            end
        end
        step_rem = rem;
        step_quo = quo;
    end

    assign div_last = (r_step == '0);

    // Shared multiplier: speed times period, or average times 255.
    always_comb begin
        if (r_state == S_MUL_BYTE) begin
            mul_a = DVSR_W'(r_avg);
            mul_b = PER_W'(BYTE_MAX);
        end else begin
            mul_a = r_wide ? r_spd16 : DVSR_W'(r_spd8);
            mul_b = r_period;
        end
        mul_p = DIV_W'(mul_a) * DIV_W'(mul_b);
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (dec_write) begin
                        n_state = S_DIV_PERIOD;
                    end else if (dec_avg) begin
                        n_state = S_DIV_AVG;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV_PERIOD: begin
                if (div_last) begin
                    if (r_dir == DIR_FWD || r_dir == DIR_REV) begin
                        n_state = S_MUL_DUTY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL_DUTY: n_state = S_DIV_DUTY;
            S_DIV_DUTY: begin
                if (div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DIV_AVG: begin
                if (div_last) begin
                    n_state = S_MUL_BYTE;
                end
            end
            S_MUL_BYTE: n_state = S_DIV_BYTE;
            S_DIV_BYTE: begin
                if (div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates driven by the sequencer.
    always_comb begin
        n_dir      = r_dir;
        n_spd8     = r_spd8;
        n_spd16    = r_spd16;
        n_wide     = r_wide;
        n_freq     = r_freq;
        n_period   = r_period;
        n_cmp_a    = r_cmp_a;
        n_cmp_b    = r_cmp_b;
        n_sum      = r_sum;
        n_smp_cnt  = r_smp_cnt;
        n_avg      = r_avg;
        n_avg_byte = r_avg_byte;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dvsr     = r_dvsr;
        n_step     = r_step;
        n_rd_valid = r_rd_valid;
        n_rd_len   = r_rd_len;
        n_rd_data  = r_rd_data;
        n_o_valid  = r_o_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_rd_valid = 1'b0;
                    n_rd_len   = LEN_NONE;
                    n_rd_data  = '0;
                    if (dec_write) begin
                        // Apply the written registers, then divide the tick rate by the frequency.
                        if (wr_mark[0]) begin
                            n_dir = wr_byte[0];
                        end
                        if (wr_mark[1]) begin
                            n_wide = 1'b0;
                            n_spd8 = wr_byte[1];
                        end
                        if (wr_mark[2] && wr_mark[3]) begin
                            n_wide  = 1'b1;
                            n_spd16 = {wr_byte[3], wr_byte[2]};
                        end
                        if (wr_mark[4] && wr_mark[5]) begin
                            n_freq = {wr_byte[5], wr_byte[4]};
                            if (n_freq < 16'(MIN_FREQ)) begin
                                n_freq = 16'(MIN_FREQ);
                            end
                        end
                        n_rem  = '0;
                        n_quo  = DIV_W'(TICK_RATE);
                        n_dvsr = n_freq;
                        n_step = STEP_W'(DIV_STEPS - 1);
                    end else if (i_in.action) begin
                        // Accumulate; the last sample of a block starts the average.
                        if (dec_avg) begin
                            n_sum     = '0;
                            n_smp_cnt = '0;
                            n_rem     = '0;
                            n_quo     = DIV_W'(sum_add);
                            n_dvsr    = DVSR_W'(SAMPLES_PER_AVERAGE);
                            n_step    = STEP_W'(DIV_STEPS - 1);
                        end else begin
                            n_sum     = sum_add;
                            n_smp_cnt = r_smp_cnt + CNT_W'(1);
                        end
                    end else if (dec_query) begin
                        // One-byte read queries.
                        n_rd_valid = 1'b1;
                        unique case (i_in.reg_addr)
                            REG_DIR: begin
                                n_rd_len  = LEN_ONE;
                                n_rd_data = 16'(r_dir);
                            end
                            REG_SPD8: begin
                                n_rd_len  = LEN_ONE;
                                n_rd_data = 16'(r_spd8);
                            end
                            REG_SPD16_LO, REG_SPD16_HI: begin
                                n_rd_len  = LEN_TWO;
                                n_rd_data = r_spd16;
                            end
                            REG_FREQ_LO, REG_FREQ_HI: begin
                                n_rd_len  = LEN_TWO;
                                n_rd_data = r_freq;
                            end
                            Q_AVG_BYTE: begin
                                n_rd_len  = LEN_ONE;
                                n_rd_data = 16'(r_avg_byte);
                            end
                            Q_AVG_LO, Q_AVG_HI: begin
                                n_rd_len  = LEN_TWO;
                                n_rd_data = 16'(r_avg);
                            end
                            Q_VERSION: begin
                                n_rd_len  = LEN_ONE;
                                n_rd_data = 16'(VERSION_CODE);
                            end
                            Q_ADDRESS: begin
                                n_rd_len  = LEN_ONE;
                                n_rd_data = 16'(ADDR_BASE + 8'(r_addr_sel));
                            end
                            default: begin
                                n_rd_valid = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_DIV_PERIOD: begin
                n_rem  = step_rem;
                n_quo  = step_quo;
                n_step = r_step - STEP_W'(1);
                if (div_last) begin
                    if (step_quo > DIV_W'(PERIOD_MAX)) begin
                        n_period = PER_W'(PERIOD_MAX);
                    end else begin
                        n_period = step_quo[PER_W-1:0];
                    end
                    if (r_dir == DIR_HALT) begin
                        n_cmp_a = '0;
                        n_cmp_b = '0;
                    end
                end
            end
            S_MUL_DUTY, S_MUL_BYTE: begin
                // Registered product becomes the next dividend.
                n_rem  = '0;
                n_quo  = mul_p;
                n_step = STEP_W'(DIV_STEPS - 1);
                if (r_state == S_MUL_BYTE) begin
                    n_dvsr = DVSR_W'(ADC_MAX);
                end else begin
                    n_dvsr = r_wide ? DVSR_W'(WIDE_MAX) : DVSR_W'(BYTE_MAX);
                end
            end
            S_DIV_DUTY: begin
                n_rem  = step_rem;
                n_quo  = step_quo;
                n_step = r_step - STEP_W'(1);
                if (div_last) begin
                    if (r_dir == DIR_FWD) begin
                        n_cmp_a = step_quo[PER_W-1:0];
                        n_cmp_b = '0;
                    end else begin
                        n_cmp_a = '0;
                        n_cmp_b = step_quo[PER_W-1:0];
                    end
                end
            end
            S_DIV_AVG: begin
                n_rem  = step_rem;
                n_quo  = step_quo;
                n_step = r_step - STEP_W'(1);
                if (div_last) begin
                    if (step_quo > DIV_W'(ADC_MAX)) begin
                        n_avg = ADC_W'(ADC_MAX);
                    end else begin
                        n_avg = step_quo[ADC_W-1:0];
                    end
                end
            end
            S_DIV_BYTE: begin
                n_rem  = step_rem;
                n_quo  = step_quo;
                n_step = r_step - STEP_W'(1);
                if (div_last) begin
                    if (step_quo > DIV_W'(BYTE_MAX)) begin
                        n_avg_byte = 8'(BYTE_MAX);
                    end else begin
                        n_avg_byte = step_quo[7:0];
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                end
            end
            default: begin
                n_o_valid = r_o_valid;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_addr_sel <= '0;
            r_dir      <= DIR_HALT;
            r_spd8     <= '0;
            r_spd16    <= '0;
            r_wide     <= 1'b0;
            r_freq     <= 16'(RESET_FREQ);
            r_period   <= PER_W'(RESET_PERIOD);
            r_cmp_a    <= '0;
            r_cmp_b    <= '0;
            r_sum      <= '0;
            r_smp_cnt  <= '0;
            r_avg      <= '0;
            r_avg_byte <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dir      <= n_dir;
            r_spd8     <= n_spd8;
            r_spd16    <= n_spd16;
            r_wide     <= n_wide;
            r_freq     <= n_freq;
            r_period   <= n_period;
            r_cmp_a    <= n_cmp_a;
            r_cmp_b    <= n_cmp_b;
            r_sum      <= n_sum;
            r_smp_cnt  <= n_smp_cnt;
            r_avg      <= n_avg;
            r_avg_byte <= n_avg_byte;
            r_o_valid  <= n_o_valid;
            if (i_cfg_we) begin
                r_addr_sel <= i_cfg_wdata;
            end
        end
    end

    // Divider, reply and output payload.
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dvsr     <= n_dvsr;
        r_step     <= n_step;
        r_rd_valid <= n_rd_valid;
        r_rd_len   <= n_rd_len;
        r_rd_data  <= n_rd_data;
        if (out_load) begin
            r_o_rd_valid <= r_rd_valid;
            r_o_rd_len   <= r_rd_len;
            r_o_rd_data  <= r_rd_data;
            r_o_period   <= r_period;
            r_o_cmp_a    <= r_cmp_a;
            r_o_cmp_b    <= r_cmp_b;
            r_o_avg      <= r_avg;
            r_o_avg_byte <= r_avg_byte;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.read_valid       = r_o_rd_valid;
    assign o_out.read_len         = r_o_rd_len;
    assign o_out.read_data        = r_o_rd_data;
    assign o_out.reload_value     = r_o_period;
    assign o_out.compare_forward  = r_o_cmp_a;
    assign o_out.compare_reverse  = r_o_cmp_b;
    assign o_out.adc_average      = r_o_avg;
    assign o_out.adc_average_byte = r_o_avg_byte;

    // The bridge never drives both channels at once.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmp_a == '0) || (r_cmp_b == '0))
        else $error("Both compare values are nonzero.");

    // The stored frequency never drops below the clamp.
    a_freq_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_freq >= 16'(MIN_FREQ))
        else $error("PWM frequency below minimum.");

    // The sample counter wraps before it reaches the block size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_smp_cnt < CNT_W'(SAMPLES_PER_AVERAGE))
        else $error("Sample counter out of range.");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("Item accepted but sequencer stayed idle.");

    // Finishing an item always presents a result.
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_o_valid)
        else $error("Finished item produced no result.");

endmodule

// ===== test/hbpr_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the H-bridge register block, keeps its own copy of
// the registers, the PWM timing and the converter averaging, and compares every
// result item with the reply predicted for the oldest accepted input item.
module hbpr_checker
    import hbpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  [3:0] i_cfg_wdata,
    hbpr_in_if    in_ch,
    hbpr_out_if   out_ch,
    output int    o_replies_due,
    output int    o_mismatches
);

    typedef struct packed {
        logic              read_valid;
        logic [1:0]        read_len;
        logic [15:0]       read_data;
        logic [PER_W-1:0]  reload_value;
        logic [PER_W-1:0]  compare_forward;
        logic [PER_W-1:0]  compare_reverse;
        logic [ADC_W-1:0]  adc_average;
        logic [7:0]        adc_average_byte;
    } t_reply;

    // Shadow copy of the block state.
    logic [3:0]       strap;
    logic [7:0]       direction;
    logic [7:0]       spd8;
    logic [15:0]      spd16;
    logic             wide;
    logic [15:0]      freq_shadow;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] cmp_fwd;
    logic [PER_W-1:0] cmp_rev;
    int unsigned      sum_acc;
    int unsigned      sample_cnt;
    logic [ADC_W-1:0] avg_value;
    logic [7:0]       avg_byte;

    t_reply    reply_queue[$];
    int        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic void clear_state();
        strap       = '0;
        direction   = DIR_HALT;
        spd8        = '0;
        spd16       = '0;
        wide        = 1'b0;
        freq_shadow = 16'(RESET_FREQ);
        period      = PER_W'(RESET_PERIOD);
        cmp_fwd     = '0;
        cmp_rev     = '0;
        sum_acc     = 0;
        sample_cnt  = 0;
        avg_value   = '0;
        avg_byte    = '0;
    endfunction

    // Compare value of the active channel, floor(speed * period / full scale).
    function automatic logic [PER_W-1:0] duty();
        longint prod;
        if (wide) begin
            prod = longint'(spd16) * longint'(period) / longint'(WIDE_MAX);
        end else begin
            prod = longint'(spd8) * longint'(period) / longint'(BYTE_MAX);
        end
        return prod[PER_W-1:0];
    endfunction

    // Every accepted write recomputes the period and the active compare.
    function automatic void retime();
        int unsigned ticks;
        ticks = TICK_RATE / int'(freq_shadow);
        if (ticks > PERIOD_MAX) ticks = PERIOD_MAX;
        period = ticks[PER_W-1:0];
        case (direction)
            DIR_HALT: begin
                cmp_fwd = '0;
                cmp_rev = '0;
            end
            DIR_FWD: begin
                cmp_fwd = duty();
                cmp_rev = '0;
            end
            DIR_REV: begin
                cmp_fwd = '0;
                cmp_rev = duty();
            end
            default: begin
                // An unknown direction leaves both compares as they were.
            end
        endcase
    endfunction

    // Scatter the data bytes over registers 0 to 5; the 16-bit values only
    // count when both of their bytes are part of the same transaction.
    function automatic void apply_write(input logic [7:0] start, input logic [3:0] len,
                                        input logic [5:0][7:0] bytes);
        logic [5:0][7:0] staged;
        logic [5:0]      hit;
        logic [15:0]     freq;
        int              idx;
        staged = '0;
        hit    = '0;
        for (int i = 0; i < 6 && i + 1 < int'(len); i++) begin
            idx = int'(start) + i;
            if (idx <= LAST_REG) begin
                staged[idx] = bytes[i];
                hit[idx]    = 1'b1;
            end
        end
        if (hit[REG_DIR]) direction = staged[REG_DIR];
        if (hit[REG_SPD8]) begin
            wide = 1'b0;
            spd8 = staged[REG_SPD8];
        end
        if (hit[REG_SPD16_LO] && hit[REG_SPD16_HI]) begin
            wide  = 1'b1;
            spd16 = {staged[REG_SPD16_HI], staged[REG_SPD16_LO]};
        end
        if (hit[REG_FREQ_LO] && hit[REG_FREQ_HI]) begin
            freq = {staged[REG_FREQ_HI], staged[REG_FREQ_LO]};
            if (freq < MIN_FREQ) freq = 16'(MIN_FREQ);
            freq_shadow = freq;
        end
        retime();
    endfunction

    // Sum samples; at the end of a block take the average and its 8-bit form.
    function automatic void accumulate(input logic [ADC_W-1:0] sample);
        int unsigned avg;
        sum_acc    += sample;
        sample_cnt += 1;
        if (sample_cnt >= SAMPLES_PER_AVERAGE) begin
            avg = sum_acc / SAMPLES_PER_AVERAGE;
            if (avg > ADC_MAX) avg = ADC_MAX;
            avg_value  = avg[ADC_W-1:0];
            avg_byte   = 8'(avg * BYTE_MAX / ADC_MAX);
            sum_acc    = 0;
            sample_cnt = 0;
        end
    endfunction

    // Update the shadow state for one input item and return the reply it causes.
    function automatic t_reply predict_reply(input logic action, input logic [7:0] start,
                                             input logic [3:0] len,
                                             input logic [5:0][7:0] bytes,
                                             input logic [ADC_W-1:0] sample);
        t_reply r;
        r = '0;
        if (action) begin
            accumulate(sample);
        end else if (len > 1 && start <= LAST_REG) begin
            if (len <= MAX_WR_LEN) apply_write(start, len, bytes);
        end else if (len == 1) begin
            r.read_valid = 1'b1;
            case (start)
                REG_DIR: begin
                    r.read_len  = LEN_ONE;
                    r.read_data = 16'(direction);
                end
                REG_SPD8: begin
                    r.read_len  = LEN_ONE;
                    r.read_data = 16'(spd8);
                end
                REG_SPD16_LO, REG_SPD16_HI: begin
                    r.read_len  = LEN_TWO;
                    r.read_data = spd16;
                end
                REG_FREQ_LO, REG_FREQ_HI: begin
                    r.read_len  = LEN_TWO;
                    r.read_data = freq_shadow;
                end
                Q_AVG_BYTE: begin
                    r.read_len  = LEN_ONE;
                    r.read_data = 16'(avg_byte);
                end
                Q_AVG_LO, Q_AVG_HI: begin
                    r.read_len  = LEN_TWO;
                    r.read_data = 16'(avg_value);
                end
                Q_VERSION: begin
                    r.read_len  = LEN_ONE;
                    r.read_data = 16'(VERSION_CODE);
                end
                Q_ADDRESS: begin
                    r.read_len  = LEN_ONE;
                    r.read_data = 16'(ADDR_BASE + 8'(strap));
                end
                default: begin
                    r.read_valid = 1'b0;
                end
            endcase
        end
        r.reload_value     = period;
        r.compare_forward  = cmp_fwd;
        r.compare_reverse  = cmp_rev;
        r.adc_average      = avg_value;
        r.adc_average_byte = avg_byte;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Results are checked before the item accepted at the same edge is predicted,
    // since a result always belongs to an earlier item.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            clear_state();
            reply_queue.delete();
        end else begin
            if (i_cfg_we) strap = i_cfg_wdata;
            if (out_ch.valid && out_ch.ready) begin
                if (reply_queue.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result item expected none, got read_data %0d reload %0d",
                             $time, out_ch.read_data, out_ch.reload_value);
                end else begin
                    want = reply_queue.pop_front();
                    compare_field("read_valid", 16'(want.read_valid), 16'(out_ch.read_valid));
                    compare_field("read_len", 16'(want.read_len), 16'(out_ch.read_len));
                    compare_field("read_data", want.read_data, out_ch.read_data);
                    compare_field("reload_value", 16'(want.reload_value),
                                  16'(out_ch.reload_value));
                    compare_field("compare_forward", 16'(want.compare_forward),
                                  16'(out_ch.compare_forward));
                    compare_field("compare_reverse", 16'(want.compare_reverse),
                                  16'(out_ch.compare_reverse));
                    compare_field("adc_average", 16'(want.adc_average),
                                  16'(out_ch.adc_average));
                    compare_field("adc_average_byte", 16'(want.adc_average_byte),
                                  16'(out_ch.adc_average_byte));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                reply_queue.push_back(predict_reply(in_ch.action, in_ch.reg_addr,
                    in_ch.byte_count,
                    {in_ch.data_byte5, in_ch.data_byte4, in_ch.data_byte3,
                     in_ch.data_byte2, in_ch.data_byte1, in_ch.data_byte0},
                    in_ch.adc_sample));
            end
        end
        o_replies_due <= reply_queue.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Drives bus transactions and converter samples into the H-bridge register
// block: a directed pass over the register map and the corner cases, then
// random phases under different address straps, with random idling on both
// sides, one stretch without idling and one long receiver hold-off.
module testbench;
    import hbpr_pkg::*;

    typedef struct packed {
        logic             action;
        logic [7:0]       reg_addr;
        logic [3:0]       byte_count;
        logic [5:0][7:0]  data;
        logic [ADC_W-1:0] adc_sample;
    } t_bus_item;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 18;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;
    bit         idle_on   = 1'b1;
    bit         hold_req  = 1'b0;
    bit         hold_done = 1'b0;
    int         replies_due;
    int         mismatches;

    hbpr_in_if  in_ch ();
    hbpr_out_if out_ch ();

    hbridge_pwm_register_block_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    hbpr_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .o_replies_due (replies_due),
        .o_mismatches  (mismatches)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off when requested.
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic present(input t_bus_item it);
        in_ch.action     <= it.action;
        in_ch.reg_addr   <= it.reg_addr;
        in_ch.byte_count <= it.byte_count;
        in_ch.data_byte0 <= it.data[0];
        in_ch.data_byte1 <= it.data[1];
        in_ch.data_byte2 <= it.data[2];
        in_ch.data_byte3 <= it.data[3];
        in_ch.data_byte4 <= it.data[4];
        in_ch.data_byte5 <= it.data[5];
        in_ch.adc_sample <= it.adc_sample;
    endtask

    // Offer one item, with an optional idle gap first, and wait until it is taken.
    task automatic offer(input t_bus_item it);
        int gap;
        gap = (idle_on && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 40) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        present(it);
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and let every outstanding result come out.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (replies_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_strap(input logic [3:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_bus_item scramble();
        t_bus_item it;
        it.action     = 1'($urandom_range(1));
        it.reg_addr   = 8'($urandom_range(255));
        it.byte_count = 4'($urandom_range(15));
        it.data       = 48'({$urandom, $urandom});
        it.adc_sample = ADC_W'($urandom_range(ADC_MAX));
        return it;
    endfunction

    function automatic t_bus_item txn(input logic [7:0] start, input logic [3:0] len,
                                      input logic [47:0] payload);
        t_bus_item it;
        it = '0;
        it.reg_addr   = start;
        it.byte_count = len;
        it.data       = payload;
        return it;
    endfunction

    function automatic t_bus_item sample_item(input logic [ADC_W-1:0] value);
        t_bus_item it;
        it = scramble();
        it.action     = 1'b1;
        it.adc_sample = value;
        return it;
    endfunction

    // Mostly well-formed writes and queries, some stray samples and pure noise.
    function automatic t_bus_item random_item();
        t_bus_item it;
        int        pick;
        int        t;
        it   = scramble();
        pick = $urandom_range(99);
        if (pick < 48) begin
            it.action     = 1'b0;
            it.reg_addr   = 8'($urandom_range(LAST_REG));
            it.byte_count = 4'($urandom_range(2, MAX_WR_LEN));
            for (int i = 0; i < 6; i++) begin
                t = int'(it.reg_addr) + i;
                if (t == REG_DIR) begin
                    case ($urandom_range(5))
                        0: it.data[i] = DIR_HALT;
                        1, 2: it.data[i] = DIR_FWD;
                        3, 4: it.data[i] = DIR_REV;
                        default: ;
                    endcase
                end
                // A zero high byte often drives the frequency under the minimum.
                if (t == REG_FREQ_HI && $urandom_range(2) == 0) it.data[i] = '0;
            end
        end else if (pick < 80) begin
            it.action     = 1'b0;
            it.byte_count = 4'd1;
            case ($urandom_range(13))
                0: it.reg_addr = REG_DIR;
                1: it.reg_addr = REG_SPD8;
                2: it.reg_addr = REG_SPD16_LO;
                3: it.reg_addr = REG_SPD16_HI;
                4: it.reg_addr = REG_FREQ_LO;
                5: it.reg_addr = REG_FREQ_HI;
                6: it.reg_addr = Q_AVG_BYTE;
                7: it.reg_addr = Q_AVG_LO;
                8: it.reg_addr = Q_AVG_HI;
                9: it.reg_addr = Q_VERSION;
                10: it.reg_addr = Q_ADDRESS;
                default: ;
            endcase
        end else if (pick < 90) begin
            it.action = 1'b1;
        end
        return it;
    endfunction

    // Random phase; now and then a whole averaging block of samples in a row.
    task automatic random_phase(input int count);
        int sent;
        int level;
        logic [ADC_W-1:0] value;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 3) begin
                level = $urandom_range(2);
                repeat (SAMPLES_PER_AVERAGE) begin
                    case (level)
                        0: value = ADC_W'(ADC_MAX);
                        1: value = '0;
                        default: value = ADC_W'($urandom_range(ADC_MAX));
                    endcase
                    offer(sample_item(value));
                end
                sent += SAMPLES_PER_AVERAGE;
            end else begin
                offer(random_item());
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        present('0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of speed and frequency, every register and query.
        offer(txn(Q_ADDRESS, 4'd1, 48'h0));
        offer(txn(REG_DIR, 4'd3, 48'h0000_0000_FF01));
        offer(txn(REG_FREQ_LO, 4'd3, 48'h0000_0000_FFFF));
        offer(txn(REG_FREQ_LO, 4'd3, 48'h0000_0000_0000));
        offer(txn(REG_SPD16_LO, 4'd3, 48'h0000_0000_FFFF));
        offer(txn(REG_DIR, 4'd2, 48'h0000_0000_0002));
        offer(txn(REG_DIR, 4'd2, 48'h0000_0000_00FF));
        offer(txn(REG_DIR, 4'd7, 48'h03E8_1234_8001));
        offer(txn(REG_FREQ_HI, 4'd7, 48'hFFFF_FFFF_FF00));
        offer(txn(REG_SPD16_HI, 4'd3, 48'h0000_0000_5555));
        offer(txn(REG_DIR, 4'd8, 48'h0000_0000_0002));
        offer(txn(REG_DIR, 4'd15, 48'hFFFF_FFFF_FF02));
        offer(txn(REG_DIR, 4'd0, 48'h0000_0000_0002));
        offer(txn(8'h06, 4'd3, 48'h0000_0000_0101));
        offer(txn(REG_SPD8, 4'd2, 48'h0000_0000_0000));
        offer(txn(REG_DIR, 4'd1, 48'h0));
        offer(txn(REG_SPD8, 4'd1, 48'h0));
        offer(txn(REG_SPD16_LO, 4'd1, 48'h0));
        offer(txn(REG_SPD16_HI, 4'd1, 48'h0));
        offer(txn(REG_FREQ_LO, 4'd1, 48'h0));
        offer(txn(REG_FREQ_HI, 4'd1, 48'h0));
        offer(sample_item(ADC_W'(ADC_MAX)));
        offer(sample_item('0));
        offer(txn(Q_AVG_BYTE, 4'd1, 48'h0));
        offer(txn(Q_AVG_LO, 4'd1, 48'h0));
        offer(txn(Q_AVG_HI, 4'd1, 48'h0));
        offer(txn(Q_VERSION, 4'd1, 48'h0));
        offer(txn(8'h11, 4'd1, 48'h0));
        drain();

        write_strap(4'hF);
        random_phase(500);
        drain();

        // Long receiver hold-off so the block fills up and stalls its input.
        write_strap(4'h0);
        hold_req = 1'b1;
        random_phase(500);
        drain();

        // A stretch with no idling on either side.
        write_strap(4'($urandom_range(1, 14)));
        idle_on = 1'b0;
        random_phase(300);
        idle_on = 1'b1;
        random_phase(200);
        drain();

        write_strap(4'hF);
        random_phase(500);
        drain();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hbpr_pkg.sv
design/hbpr_if.sv
design/hbridge_pwm_register_block_core.sv
test/hbpr_checker.sv
test/testbench.sv
